>>> design/svpwm_pkg.sv
// Shared constants and types of the space vector duty generator.
// No dependencies.
`default_nettype none
package svpwm_pkg;
	localparam int unsigned DUTY_W = 32;
	localparam int unsigned SECTOR_W = 3;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned ROOT_W = 32;
	localparam int unsigned REM_W = 36;

	localparam logic [23:0] SQRT3_HALF_Q24 = 24'd14529495;
	localparam logic [31:0] ONE_Q24 = 32'h0100_0000;
	localparam logic [31:0] HALF_Q24 = 32'h0080_0000;
	localparam logic [31:0] MAG_SAT = 32'h7FFF_FFFF;

	typedef struct packed {
		logic [DUTY_W-1:0] ta;
		logic [DUTY_W-1:0] tb;
		logic [DUTY_W-1:0] tc;
		logic [SECTOR_W-1:0] sector;
		logic signed [31:0] alpha;
		logic signed [31:0] beta;
	} entry_t;
endpackage
`default_nettype wire

>>> design/svpwm_if.sv
// Handshake channels of the duty generator: input pair and duty result.
// Depends on nothing.
`default_nettype none
interface svpwm_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] alpha;
	logic signed [31:0] beta;
	modport source (output valid, output alpha, output beta, input ready);
	modport sink (input valid, input alpha, input beta, output ready);
endinterface

interface svpwm_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] duty_a;
	logic signed [31:0] duty_b;
	logic signed [31:0] duty_c;
	logic [2:0] sector;
	modport source (output valid, output duty_a, output duty_b, output duty_c,
		output sector, input ready);
	modport sink (input valid, input duty_a, input duty_b, input duty_c,
		input sector, output ready);
endinterface
`default_nettype wire

>>> design/svpwm_front.sv
// Front part: scale alpha, classify the sector, form the plain duties.
// Depends on svpwm_pkg.
`default_nettype none
module svpwm_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic signed [31:0] in_alpha,
	input wire logic signed [31:0] in_beta,
	output logic q_valid,
	input wire logic q_ready,
	output svpwm_pkg::entry_t q_data
);
	import svpwm_pkg::*;

	logic en;
	logic v_s1, v_s2;
	logic signed [31:0] a_s1, b_s1;
	logic signed [56:0] p_s1;
	entry_t e_s2;

	logic [31:0] ka, kb, va, vb, vc, pb, pc;
	logic [31:0] ta, tb, tc;
	logic [2:0] sec;

	function automatic logic [31:0] asr1(input logic [31:0] x);
		return {x[31], x[31:1]};
	endfunction

	function automatic logic is_pos(input logic [31:0] x);
		return !x[31] && (x != '0);
	endfunction

	assign en = !v_s2 || q_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= in_alpha;
			b_s1 <= in_beta;
			p_s1 <= 57'(in_alpha * $signed({1'b0, SQRT3_HALF_Q24}));
			e_s2 <= '{ta: ta, tb: tb, tc: tc, sector: sec, alpha: a_s1, beta: b_s1};
		end
	end

	always_comb begin
		// floor shift of the product gives Ka
		ka = p_s1[55:24];
		kb = asr1(b_s1);
		va = b_s1;
		pb = ka - kb;
		pc = 32'd0 - ka - kb;
		sec = {is_pos(pc), is_pos(pb), is_pos(va)};
		vb = ka + kb;
		vc = kb - ka;
		case (sec)
			3'd1: begin
				tb = asr1(ONE_Q24 - vc - vb);
				ta = tb + vc;
				tc = ta + vb;
			end
			3'd2: begin
				ta = asr1(ONE_Q24 - vb + va);
				tc = ta + vb;
				tb = tc - va;
			end
			3'd3: begin
				ta = asr1(ONE_Q24 + vc - va);
				tb = ta - vc;
				tc = tb + va;
			end
			3'd4: begin
				tc = asr1(ONE_Q24 + va - vc);
				tb = tc - va;
				ta = tb + vc;
			end
			3'd5: begin
				tb = asr1(ONE_Q24 - va + vb);
				tc = tb + va;
				ta = tc - vb;
			end
			3'd6: begin
				tc = asr1(ONE_Q24 + vb + vc);
				ta = tc - vb;
				tb = ta - vc;
			end
			default: begin
				ta = HALF_Q24;
				tb = HALF_Q24;
				tc = HALF_Q24;
			end
		endcase
		ta = ONE_Q24 - {ta[30:0], 1'b0};
		tb = ONE_Q24 - {tb[30:0], 1'b0};
		tc = ONE_Q24 - {tc[30:0], 1'b0};
	end

	assign q_valid = v_s2;
	assign q_data = e_s2;
endmodule
`default_nettype wire

>>> design/svpwm_queue.sv
// Small queue between front and back parts.
// Depends on svpwm_pkg.
`default_nettype none
module svpwm_queue #(
	parameter int unsigned DEPTH = svpwm_pkg::QUEUE_DEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_valid,
	output logic wr_ready,
	input wire svpwm_pkg::entry_t wr_data,
	output logic rd_valid,
	input wire logic rd_ready,
	output svpwm_pkg::entry_t rd_data
);
	import svpwm_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	entry_t mem [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic push, pop;

	assign wr_ready = (cnt_q != CW'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;
	assign rd_data = mem[rp_q];

	function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) mem[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= nxt(wp_q);
			if (pop) rp_q <= nxt(rp_q);
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule
`default_nettype wire

>>> design/svpwm_back.sv
// Back part: vector magnitude by a bit-per-stage root pipeline, then mode 1 offset.
// Depends on svpwm_pkg.
`default_nettype none
module svpwm_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic pwm_mode,
	input wire logic q_valid,
	output logic q_ready,
	input wire svpwm_pkg::entry_t q_data,
	output logic out_valid,
	input wire logic out_ready,
	output logic [31:0] out_a,
	output logic [31:0] out_b,
	output logic [31:0] out_c,
	output logic [2:0] out_sector
);
	import svpwm_pkg::*;

	localparam int unsigned NS = ROOT_W;

	logic en;
	logic v_s1, v_s2;
	entry_t e_s1, e_s2;
	logic [63:0] sqa_s1, sqb_s1, n_s2;
	logic [31:0] absa, absb;

	logic st_v_q [NS];
	entry_t st_e_q [NS];
	logic [63:0] st_n_q [NS];
	logic [ROOT_W-1:0] st_r_q [NS];
	logic [REM_W-1:0] st_m_q [NS];

	logic out_v_q;
	logic [31:0] oa_q, ob_q, oc_q;
	logic [2:0] os_q;

	assign en = !out_v_q || out_ready;
	assign q_ready = en;

	assign absa = q_data.alpha[31] ? 32'd0 - q_data.alpha : q_data.alpha;
	assign absb = q_data.beta[31] ? 32'd0 - q_data.beta : q_data.beta;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			for (int i = 0; i < NS; i++) st_v_q[i] <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_s1 <= q_valid;
			v_s2 <= v_s1;
			st_v_q[0] <= v_s2;
			for (int i = 1; i < NS; i++) st_v_q[i] <= st_v_q[i-1];
			out_v_q <= st_v_q[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s1 <= q_data;
			sqa_s1 <= absa * absa;
			sqb_s1 <= absb * absb;
			e_s2 <= e_s1;
			n_s2 <= sqa_s1 + sqb_s1;
		end
	end

	// one root bit per stage, from the top pair of the radicand down
	for (genvar k = 0; k < NS; k++) begin : g_root
		logic [REM_W-1:0] rin, rem, trial;
		logic [ROOT_W-1:0] root;
		logic [63:0] n;
		entry_t e;
		if (k == 0) begin : g_first
			assign rin = '0;
			assign root = '0;
			assign n = n_s2;
			assign e = e_s2;
		end else begin : g_next
			assign rin = st_m_q[k-1];
			assign root = st_r_q[k-1];
			assign n = st_n_q[k-1];
			assign e = st_e_q[k-1];
		end
		assign rem = {rin[REM_W-3:0], n[63-2*k -: 2]};
		assign trial = {(REM_W-ROOT_W-2)'(0), root, 2'b01};
		always_ff @(posedge clk) begin
			if (en) begin
				st_n_q[k] <= n;
				st_e_q[k] <= e;
				if (rem >= trial) begin
					st_m_q[k] <= rem - trial;
					st_r_q[k] <= {root[ROOT_W-2:0], 1'b1};
				end else begin
					st_m_q[k] <= rem;
					st_r_q[k] <= {root[ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	logic [31:0] mag, mn, ta, tb, tc;
	entry_t ef;

	function automatic logic [31:0] min_s(input logic [31:0] x, input logic [31:0] y);
		return ($signed(x) < $signed(y)) ? x : y;
	endfunction

	always_comb begin
		ef = st_e_q[NS-1];
		mag = st_r_q[NS-1][ROOT_W-1] ? MAG_SAT : st_r_q[NS-1];
		mn = min_s(min_s(ef.ta, ef.tb), ef.tc);
		if (pwm_mode) begin
			ta = ef.ta - mn - mag;
			tb = ef.tb - mn - mag;
			tc = ef.tc - mn - mag;
		end else begin
			ta = ef.ta;
			tb = ef.tb;
			tc = ef.tc;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			oa_q <= ta;
			ob_q <= tb;
			oc_q <= tc;
			os_q <= ef.sector;
		end
	end

	assign out_valid = out_v_q;
	assign out_a = oa_q;
	assign out_b = ob_q;
	assign out_c = oc_q;
	assign out_sector = os_q;
endmodule
`default_nettype wire

>>> design/space_vector_pwm_duty_generator_unit.sv
// Top level of the space vector duty generator: front, queue and back parts.
// Depends on svpwm_pkg, svpwm_if, svpwm_front, svpwm_queue, svpwm_back.
//
//  channel   | direction | carries
//  ----------+-----------+-------------------------------------------
//  in_ch     | sink      | alpha, beta (signed Q24)
//  out_ch    | source    | duty_a, duty_b, duty_c (Q24), sector
//  cfg_we/wd | write     | pwm_mode, one bit
//
// One transfer per cycle is sustained in and out while out_ch is ready. Data
// passes through two front stages, the queue, two squaring stages,
// 32 root stages (one result bit each) and the output register.
// arst_n clears all valid flags, the queue pointers and pwm_mode.
// A stall at out_ch holds the back part; the front keeps going until the
// queue fills, then drops in_ch.ready.
`default_nettype none
module space_vector_pwm_duty_generator_unit #(
	parameter int unsigned QUEUE_DEPTH = svpwm_pkg::QUEUE_DEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic cfg_wdata,
	svpwm_in_if.sink in_ch,
	svpwm_out_if.source out_ch
);
	import svpwm_pkg::*;

	logic mode_q;
	logic fq_valid, fq_ready, bq_valid, bq_ready;
	entry_t fq_data, bq_data;
	logic [31:0] da, db, dc;

	// hold the mode register; the user must write only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mode_q <= 1'b0;
		else if (cfg_we) mode_q <= cfg_wdata;
	end

	svpwm_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.in_alpha(in_ch.alpha), .in_beta(in_ch.beta),
		.q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
	);

	svpwm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
		.rd_valid(bq_valid), .rd_ready(bq_ready), .rd_data(bq_data)
	);

	svpwm_back u_back (
		.clk(clk), .arst_n(arst_n), .pwm_mode(mode_q),
		.q_valid(bq_valid), .q_ready(bq_ready), .q_data(bq_data),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_a(da), .out_b(db), .out_c(dc), .out_sector(out_ch.sector)
	);

	assign out_ch.duty_a = da;
	assign out_ch.duty_b = db;
	assign out_ch.duty_c = dc;
endmodule
`default_nettype wire
